/* src/bblru_pkg.sv */
package bblru_pkg;

	localparam int ENTRIES_DEF = 64;
	localparam int KEY_W       = 32;
	localparam int SIZE_W      = 32;
	localparam int STAMP_W     = 48;
	localparam int OUT_TOTAL_W = 40;
	localparam int OUT_CNT_W   = 7;

	localparam logic [SIZE_W-1:0] BUDGET_RST = 32'h1000_0000;

	localparam logic OP_LOOKUP = 1'b0;
	localparam logic OP_INSERT = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [KEY_W-1:0]   tag;
		logic [SIZE_W-1:0]  size;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND,
		S_FIND_END,
		S_APPLY,
		S_CHECK,
		S_VSCAN,
		S_VSCAN_END,
		S_EVICT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic scan_start;
		logic scan_step;
		logic take_item;
		logic apply;
		logic evict;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic addr_last;
		logic ins_ok;
		logic over_budget;
		logic vic_found;
	} status_t;

endpackage

/* src/bblru_ctrl.sv */
module bblru_ctrl
	import bblru_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	output logic    out_valid,
	input  logic    out_stall,
	input  status_t st,
	output cmd_t    cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= cmd.load_out | (out_valid_q & out_stall);
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.addr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.take_item  = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_FIND;
				end
			end
			S_FIND: begin
				cmd.scan_step = 1'b1;
				if (st.addr_last) state_d = S_FIND_END;
			end
			S_FIND_END: state_d = S_APPLY;
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = st.ins_ok ? S_CHECK : S_DONE;
			end
			S_CHECK: begin
				if (st.over_budget) begin
					cmd.scan_start = 1'b1;
					state_d        = S_VSCAN;
				end else begin
					state_d = S_DONE;
				end
			end
			S_VSCAN: begin
				cmd.scan_step = 1'b1;
				if (st.addr_last) state_d = S_VSCAN_END;
			end
			S_VSCAN_END: state_d = S_EVICT;
			S_EVICT: begin
				// every remaining entry pinned: stop evicting
				if (st.vic_found) begin
					cmd.evict = 1'b1;
					state_d   = S_CHECK;
				end else begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_accept_starts_find: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_FIND))
		else $error("accepted request did not start the tag scan");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while still held");

	a_evict_rechecks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |=> (state_q == S_CHECK))
		else $error("eviction not followed by budget check");
`endif

endmodule

/* src/bblru_dpath.sv */
module bblru_dpath
	import bblru_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                st,
	input  logic                   cfg_wr_en,
	input  logic [SIZE_W-1:0]      cfg_wr_data,
	input  logic                   opcode,
	input  logic [KEY_W-1:0]       key_tag,
	input  logic [SIZE_W-1:0]      item_bytes,
	input  logic [KEY_W-1:0]       pinned_tag,
	output logic                   hit,
	output logic [SIZE_W-1:0]      entry_bytes,
	output logic [OUT_CNT_W-1:0]   evicted_count,
	output logic [OUT_TOTAL_W-1:0] total_bytes,
	output logic [OUT_CNT_W-1:0]   entry_count
);

	localparam int AW      = $clog2(ENTRIES);
	localparam int CW      = $clog2(ENTRIES + 1);
	localparam int CNT_X   = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;
	localparam int TOTAL_W = (SIZE_W + CW > OUT_TOTAL_W) ? SIZE_W + CW : OUT_TOTAL_W;

	entry_t mem [ENTRIES];

	logic [SIZE_W-1:0]  budget_q;
	logic [AW-1:0]      addr_q;
	logic               rd_vld_s1;
	logic [AW-1:0]      rd_idx_s1;
	entry_t             rd_data_s1;

	// latched request
	logic               op_q;
	logic [KEY_W-1:0]   key_q;
	logic [SIZE_W-1:0]  bytes_q;
	logic [KEY_W-1:0]   pin_q;

	// scan results
	logic               hit_q;
	logic [AW-1:0]      hit_slot_q;
	logic [SIZE_W-1:0]  hit_size_q;
	logic               free_q;
	logic [AW-1:0]      free_slot_q;
	logic               vic_q;
	logic [AW-1:0]      vic_slot_q;
	logic [SIZE_W-1:0]  vic_size_q;
	logic [STAMP_W-1:0] vic_stamp_q;

	// architectural state
	logic [TOTAL_W-1:0] total_q;
	logic [CNT_X-1:0]   cnt_q;
	logic [STAMP_W-1:0] use_ctr_q;

	// per-request results
	logic               res_hit_q;
	logic               key_here_q;
	logic [AW-1:0]      key_slot_q;
	logic [SIZE_W-1:0]  ent_bytes_q;
	logic [CNT_X-1:0]   evict_q;

	// result register
	logic               out_hit_q;
	logic [SIZE_W-1:0]  out_bytes_q;
	logic [CNT_X-1:0]   out_evict_q;
	logic [TOTAL_W-1:0] out_total_q;
	logic [CNT_X-1:0]   out_cnt_q;

	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	entry_t             wr_data;
	logic [STAMP_W-1:0] stamp_new;
	logic               ins_ok;
	logic [AW-1:0]      ins_slot;
	logic [SIZE_W-1:0]  ins_sub;
	logic               addr_last;

	assign addr_last = (addr_q == AW'(ENTRIES - 1));
	assign stamp_new = use_ctr_q + STAMP_W'(1);
	assign ins_ok    = (op_q == OP_INSERT) && (hit_q || free_q || vic_q);

	always_comb begin
		priority if (hit_q) begin
			ins_slot = hit_slot_q;
			ins_sub  = hit_size_q;
		end else if (free_q) begin
			ins_slot = free_slot_q;
			ins_sub  = '0;
		end else begin
			ins_slot = vic_slot_q;
			ins_sub  = vic_size_q;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		if (cmd.clr_step) begin
			wr_en = 1'b1;
		end else if (cmd.apply) begin
			wr_data.valid = 1'b1;
			wr_data.tag   = key_q;
			wr_data.stamp = stamp_new;
			if (op_q == OP_LOOKUP) begin
				wr_en        = hit_q;
				wr_addr      = hit_slot_q;
				wr_data.size = hit_size_q;
			end else begin
				wr_en        = ins_ok;
				wr_addr      = ins_slot;
				wr_data.size = bytes_q;
			end
		end else if (cmd.evict) begin
			wr_en   = 1'b1;
			wr_addr = vic_slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		rd_data_s1 <= mem[addr_q];
		rd_idx_s1  <= addr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q  <= BUDGET_RST;
			addr_q    <= '0;
			rd_vld_s1 <= 1'b0;
			total_q   <= '0;
			cnt_q     <= '0;
			use_ctr_q <= '0;
		end else begin
			if (cfg_wr_en) budget_q <= cfg_wr_data;
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.scan_start) begin
				addr_q <= '0;
			end else if (cmd.clr_step || cmd.scan_step) begin
				addr_q <= addr_last ? '0 : addr_q + AW'(1);
			end
			if (cmd.apply) begin
				if (op_q == OP_LOOKUP) begin
					if (hit_q) use_ctr_q <= stamp_new;
				end else if (ins_ok) begin
					use_ctr_q <= stamp_new;
					total_q   <= total_q - TOTAL_W'(ins_sub) + TOTAL_W'(bytes_q);
					if (!hit_q && free_q) cnt_q <= cnt_q + CNT_X'(1);
				end
			end
			if (cmd.evict) begin
				total_q <= total_q - TOTAL_W'(vic_size_q);
				cnt_q   <= cnt_q - CNT_X'(1);
			end
		end
	end

	// scan compare, one entry per cycle
	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			op_q    <= opcode;
			key_q   <= key_tag;
			bytes_q <= item_bytes;
			pin_q   <= pinned_tag;
		end
		if (cmd.scan_start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			vic_q  <= 1'b0;
		end else if (rd_vld_s1) begin
			if (rd_data_s1.valid) begin
				if (!hit_q && rd_data_s1.tag == key_q) begin
					hit_q      <= 1'b1;
					hit_slot_q <= rd_idx_s1;
					hit_size_q <= rd_data_s1.size;
				end
				// strict compare keeps the lowest slot on equal stamps
				if (rd_data_s1.tag != pin_q &&
				    (!vic_q || rd_data_s1.stamp < vic_stamp_q)) begin
					vic_q       <= 1'b1;
					vic_slot_q  <= rd_idx_s1;
					vic_size_q  <= rd_data_s1.size;
					vic_stamp_q <= rd_data_s1.stamp;
				end
			end else if (!free_q) begin
				free_q      <= 1'b1;
				free_slot_q <= rd_idx_s1;
			end
		end
		if (cmd.apply) begin
			res_hit_q <= hit_q;
			evict_q   <= '0;
			if (op_q == OP_LOOKUP) begin
				key_here_q  <= hit_q;
				key_slot_q  <= hit_slot_q;
				ent_bytes_q <= hit_q ? hit_size_q : '0;
			end else begin
				key_here_q  <= ins_ok;
				key_slot_q  <= ins_slot;
				ent_bytes_q <= ins_ok ? bytes_q : '0;
				if (!hit_q && !free_q && vic_q) evict_q <= CNT_X'(1);
			end
		end
		if (cmd.evict) begin
			evict_q <= evict_q + CNT_X'(1);
			if (key_here_q && key_slot_q == vic_slot_q) begin
				key_here_q  <= 1'b0;
				ent_bytes_q <= '0;
			end
		end
		if (cmd.load_out) begin
			out_hit_q   <= res_hit_q;
			out_bytes_q <= ent_bytes_q;
			out_evict_q <= evict_q;
			out_total_q <= total_q;
			out_cnt_q   <= cnt_q;
		end
	end

	assign st.addr_last   = addr_last;
	assign st.ins_ok      = ins_ok;
	assign st.over_budget = (total_q > TOTAL_W'(budget_q)) && (cnt_q > CNT_X'(1));
	assign st.vic_found   = vic_q;

	assign hit           = out_hit_q;
	assign entry_bytes   = out_bytes_q;
	assign evicted_count = out_evict_q[OUT_CNT_W-1:0];
	assign total_bytes   = out_total_q[OUT_TOTAL_W-1:0];
	assign entry_count   = out_cnt_q[OUT_CNT_W-1:0];

`ifndef SYNTH
	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_X'(ENTRIES))
		else $error("entry count above table depth");

	a_evict_drops_total: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.evict |=> (total_q == $past(total_q) - TOTAL_W'($past(vic_size_q))))
		else $error("eviction did not remove victim bytes");
`endif

endmodule

/* src/byte_budget_lru_cache_top.sv */
// Size-bounded LRU tag cache. A lookup (opcode 0) restamps a hit; an insert
// (opcode 1) replaces or adds an entry, then evicts least recently used
// entries not matching pinned_tag while the byte total exceeds byte_budget
// and more than one entry is held. The table is one memory with a read and a
// write port, walked one entry per cycle; each request scans every tag, and
// an insert scans again for a victim before each eviction, until the budget
// holds or a scan finds every remaining entry pinned. One result per request,
// from a result register, so the next request is taken while a result waits.
// After reset a clearing pass invalidates every entry before the first
// request. byte_budget is written via cfg_wr_en/cfg_wr_data at any time.
module byte_budget_lru_cache_top
	import bblru_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [SIZE_W-1:0]      cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   opcode,
	input  logic [KEY_W-1:0]       key_tag,
	input  logic [SIZE_W-1:0]      item_bytes,
	input  logic [KEY_W-1:0]       pinned_tag,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   hit,
	output logic [SIZE_W-1:0]      entry_bytes,
	output logic [OUT_CNT_W-1:0]   evicted_count,
	output logic [OUT_TOTAL_W-1:0] total_bytes,
	output logic [OUT_CNT_W-1:0]   entry_count
);

	cmd_t    cmd;
	status_t st;

	bblru_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.st        (st),
		.cmd       (cmd)
	);

	bblru_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.opcode        (opcode),
		.key_tag       (key_tag),
		.item_bytes    (item_bytes),
		.pinned_tag    (pinned_tag),
		.hit           (hit),
		.entry_bytes   (entry_bytes),
		.evicted_count (evicted_count),
		.total_bytes   (total_bytes),
		.entry_count   (entry_count)
	);

endmodule
